// File: rtl/pkc_pkg.sv
// Package for the padded kernel convolution block.
// Field widths, request and register codes, default sizes. No dependencies.
`timescale 1ns / 1ps

package pkc_pkg;

    // default sizes for the top-level parameters
    localparam int MAX_WIDTH_DEF      = 1024;
    localparam int MAX_HEIGHT_DEF     = 1024;
    localparam int MAX_KERNEL_DEF     = 5;
    localparam int COEF_FRAC_BITS_DEF = 12;

    // fixed field widths
    localparam int REQ_W     = 2;
    localparam int CIDX_W    = 5;
    localparam int COEF_W    = 18;
    localparam int PIX_W     = 8;
    localparam int DIM_CFG_W = 11;
    localparam int KER_CFG_W = 3;

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam int CMD_FIFO_DEPTH = 4;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef enum logic [REQ_W-1:0] {
        REQ_COEF  = 2'd0,
        REQ_PIXEL = 2'd1,
        REQ_FLUSH = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_KW     = 3'd2,
        REG_KH     = 3'd3,
        REG_PAD    = 3'd4
    } t_reg_idx;

endpackage

// File: rtl/pkc_req_if.sv
// Input channel of the convolution block: request transactions.
// Depends on pkc_pkg.
`timescale 1ns / 1ps

interface pkc_req_if import pkc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [CIDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic [PIX_W-1:0]         pixel_value;

    modport source (output valid, req_type, coef_index, coef_value, pixel_value, input ready);
    modport sink   (input valid, req_type, coef_index, coef_value, pixel_value, output ready);
endinterface

// File: rtl/pkc_res_if.sv
// Output channel of the convolution block: filtered pixel transactions.
// Depends on pkc_pkg.
`timescale 1ns / 1ps

interface pkc_res_if import pkc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;
    logic             frame_last;

    modport source (output valid, out_pixel, frame_last, input ready);
    modport sink   (input valid, out_pixel, frame_last, output ready);
endinterface

// File: rtl/pkc_fifo.sv
// Small command queue between the front and back parts.
// Depends on pkc_pkg.
`timescale 1ns / 1ps

module pkc_fifo import pkc_pkg::*; #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = CMD_FIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_data [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_push, do_pop;

    always_comb begin
        o_full  = (32'(r_count) == DEPTH);
        o_empty = (r_count == '0);
        o_data  = r_data[r_rd];
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (32'(r_wr) + 32'd1 == DEPTH) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (32'(r_rd) + 32'd1 == DEPTH) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/pkc_front.sv
// Front part: accepts request transactions, tracks raster positions and
// turns each request into a command for the back part. Depends on pkc_pkg.
`timescale 1ns / 1ps

module pkc_front import pkc_pkg::*; #(
    parameter int  MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int  MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int  MAX_KERNEL = MAX_KERNEL_DEF,
    parameter type t_geom     = logic,
    parameter type t_cmd      = logic
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_restart,
    input  t_geom    i_geom,
    pkc_req_if.sink  i_req,
    output logic     o_push,
    output t_cmd     o_cmd,
    input  logic     i_full
);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int KK     = MAX_KERNEL * MAX_KERNEL;
    localparam int KI_W   = (KK > 1) ? $clog2(KK) : 1;
    localparam int NSLOT  = 2 * (MAX_KERNEL / 2) + MAX_KERNEL / 2 + 1;
    localparam int SLOT_W = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int RCV_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    logic [COL_W-1:0]  r_in_col, n_in_col, r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_in_row, n_in_row, r_out_row, n_out_row;
    logic [SLOT_W-1:0] r_in_slot, n_in_slot, r_out_slot, n_out_slot;
    logic [SLOT_W-1:0] in_slot_inc, out_slot_inc;
    logic [RCV_W-1:0]  r_rcv, n_rcv, rcv_inc;
    logic              r_in_done, n_in_done;
    logic              accept, push;
    logic              in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;
    t_cmd              cmd;

    always_comb begin
        accept       = i_req.valid && !i_full;
        rcv_inc      = r_rcv + RCV_W'(1);
        in_col_wrap  = (32'(r_in_col) + 32'd1) >= 32'(i_geom.width);
        in_row_wrap  = (32'(r_in_row) + 32'd1) >= 32'(i_geom.height);
        out_col_wrap = (32'(r_out_col) + 32'd1) >= 32'(i_geom.width);
        out_row_wrap = (32'(r_out_row) + 32'd1) >= 32'(i_geom.height);
        in_slot_inc  = (32'(r_in_slot) + 32'd1 >= NSLOT) ? '0 : r_in_slot + SLOT_W'(1);
        out_slot_inc = (32'(r_out_slot) + 32'd1 >= NSLOT) ? '0 : r_out_slot + SLOT_W'(1);

        cmd          = '0;
        cmd.coef_idx = KI_W'(i_req.coef_index);
        cmd.coef_val = i_req.coef_value;
        cmd.wr_slot  = r_in_slot;
        cmd.wr_col   = r_in_col;
        cmd.pix      = i_req.pixel_value;
        cmd.out_row  = r_out_row;
        cmd.out_col  = r_out_col;
        cmd.out_slot = r_out_slot;
        cmd.last     = out_col_wrap && out_row_wrap;
        push         = 1'b0;

        unique case (i_req.req_type)
            REQ_COEF: begin
                if (32'(i_req.coef_index) < KK) begin
                    cmd.coef_we = 1'b1;
                    push        = 1'b1;
                end
            end
            REQ_PIXEL: begin
                // pixels past the end of the frame are dropped until it drains
                if (!r_in_done) begin
                    cmd.pix_we = 1'b1;
                    cmd.emit   = rcv_inc > i_geom.lag;
                    push       = 1'b1;
                end
            end
            REQ_FLUSH: begin
                if (r_in_done) begin
                    cmd.emit = 1'b1;
                    push     = 1'b1;
                end
            end
            default: begin
            end
        endcase

        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_in_slot  = r_in_slot;
        n_in_done  = r_in_done;
        n_rcv      = r_rcv;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_out_slot = r_out_slot;

        if (accept && cmd.pix_we) begin
            n_rcv = rcv_inc;
            if (in_col_wrap) begin
                n_in_col = '0;
                if (in_row_wrap) begin
                    n_in_row  = '0;
                    n_in_slot = '0;
                    n_in_done = 1'b1;
                end else begin
                    n_in_row  = r_in_row + ROW_W'(1);
                    n_in_slot = in_slot_inc;
                end
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
        end

        if (accept && cmd.emit) begin
            if (out_col_wrap) begin
                n_out_col = '0;
                if (out_row_wrap) begin
                    // frame done: everything starts over
                    n_out_row  = '0;
                    n_out_slot = '0;
                    n_in_col   = '0;
                    n_in_row   = '0;
                    n_in_slot  = '0;
                    n_in_done  = 1'b0;
                    n_rcv      = '0;
                end else begin
                    n_out_row  = r_out_row + ROW_W'(1);
                    n_out_slot = out_slot_inc;
                end
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
        end

        if (i_restart) begin
            n_in_col   = '0;
            n_in_row   = '0;
            n_in_slot  = '0;
            n_in_done  = 1'b0;
            n_rcv      = '0;
            n_out_col  = '0;
            n_out_row  = '0;
            n_out_slot = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_in_done  <= 1'b0;
            r_rcv      <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_in_slot  <= n_in_slot;
            r_in_done  <= n_in_done;
            r_rcv      <= n_rcv;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_out_slot <= n_out_slot;
        end
    end

    assign i_req.ready = !i_full;
    assign o_push      = accept && push;
    assign o_cmd       = cmd;

endmodule

// File: rtl/pkc_back.sv
// Back part: executes commands - coefficient writes, row store writes and
// the tap-by-tap multiply-accumulate of one output pixel. Depends on pkc_pkg.
`timescale 1ns / 1ps

module pkc_back import pkc_pkg::*; #(
    parameter int  MAX_WIDTH      = MAX_WIDTH_DEF,
    parameter int  MAX_HEIGHT     = MAX_HEIGHT_DEF,
    parameter int  MAX_KERNEL     = MAX_KERNEL_DEF,
    parameter int  COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    parameter type t_geom         = logic,
    parameter type t_cmd          = logic
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_geom     i_geom,
    input  t_cmd      i_cmd,
    input  logic      i_empty,
    output logic      o_pop,
    pkc_res_if.source o_res
);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int KD_W   = $clog2(MAX_KERNEL + 1);
    localparam int KK     = MAX_KERNEL * MAX_KERNEL;
    localparam int KI_W   = (KK > 1) ? $clog2(KK) : 1;
    localparam int NSLOT  = 2 * (MAX_KERNEL / 2) + MAX_KERNEL / 2 + 1;
    localparam int SLOT_W = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int PROD_W = COEF_W + PIX_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(KK + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_TAP   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    t_cmd                     r_cmd;
    logic [KD_W-1:0]          r_h, n_h, r_w, n_w, ph, pw;
    logic [KI_W-1:0]          r_kidx, n_kidx;
    logic signed [COEF_W-1:0] r_coef [KK];
    logic [PIX_W-1:0]         r_mem [NSLOT][MAX_WIDTH];
    logic [PIX_W-1:0]         r_rd;
    logic                     r_s1_v, n_s1_v, r_s1_skip, r_s2_v;
    logic signed [COEF_W-1:0] r_s1_coef;
    logic signed [PIX_W:0]    pix_s;
    logic signed [PROD_W-1:0] r_s2_prod;
    logic signed [ACC_W-1:0]  r_acc, acc_q;
    logic                     r_out_v, r_out_last, out_load, pop;
    logic [PIX_W-1:0]         r_out_pix, res_pix;

    logic signed [ROW_W+1:0]  rr, rr_cl, hs, diff;
    logic signed [COL_W+1:0]  cc, cc_cl, ws;
    logic signed [SLOT_W+1:0] st;
    logic                     row_out, col_out, skip;
    logic [SLOT_W-1:0]        rd_slot;
    logic [COL_W-1:0]         rd_col;

    // tap address: clamp to edge, map row onto the ring of row slots
    always_comb begin
        ph = i_geom.kh >> 1;
        pw = i_geom.kw >> 1;
        hs = signed'((ROW_W+2)'(i_geom.height));
        ws = signed'((COL_W+2)'(i_geom.width));
        rr = signed'((ROW_W+2)'(r_cmd.out_row)) + signed'((ROW_W+2)'(r_h))
             - signed'((ROW_W+2)'(ph));
        cc = signed'((COL_W+2)'(r_cmd.out_col)) + signed'((COL_W+2)'(r_w))
             - signed'((COL_W+2)'(pw));
        row_out = (rr < 0) || (rr >= hs);
        col_out = (cc < 0) || (cc >= ws);
        skip    = (row_out || col_out) && i_geom.pad_zero;
        if (rr < 0) begin
            rr_cl = '0;
        end else if (rr >= hs) begin
            rr_cl = hs - (ROW_W+2)'(1);
        end else begin
            rr_cl = rr;
        end
        if (cc < 0) begin
            cc_cl = '0;
        end else if (cc >= ws) begin
            cc_cl = ws - (COL_W+2)'(1);
        end else begin
            cc_cl = cc;
        end
        diff = rr_cl - signed'((ROW_W+2)'(r_cmd.out_row));
        st   = signed'((SLOT_W+2)'(r_cmd.out_slot)) + signed'((SLOT_W+2)'(diff));
        if (st < 0) begin
            st = st + signed'((SLOT_W+2)'(NSLOT));
        end else if (st >= signed'((SLOT_W+2)'(NSLOT))) begin
            st = st - signed'((SLOT_W+2)'(NSLOT));
        end
        rd_slot = SLOT_W'(st);
        rd_col  = COL_W'(cc_cl);
    end

    // negative sums clamp to zero, so truncation toward zero reduces to a shift
    always_comb begin
        acc_q = r_acc >>> COEF_FRAC_BITS;
        if (r_acc < 0) begin
            res_pix = '0;
        end else if (acc_q > signed'(ACC_W'(PIX_MAX))) begin
            res_pix = PIX_MAX;
        end else begin
            res_pix = PIX_W'(acc_q);
        end
        pix_s = r_s1_skip ? '0 : signed'({1'b0, r_rd});
    end

    always_comb begin
        n_state  = r_state;
        n_h      = r_h;
        n_w      = r_w;
        n_kidx   = r_kidx;
        n_s1_v   = 1'b0;
        pop      = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    pop = 1'b1;
                    if (i_cmd.emit) begin
                        n_state = S_TAP;
                        n_h     = '0;
                        n_w     = '0;
                        n_kidx  = '0;
                    end
                end
            end
            S_TAP: begin
                n_s1_v = 1'b1;
                n_kidx = r_kidx + KI_W'(1);
                if (32'(r_w) + 32'd1 >= 32'(i_geom.kw)) begin
                    n_w = '0;
                    n_h = r_h + KD_W'(1);
                    if (32'(r_h) + 32'd1 >= 32'(i_geom.kh)) begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_w = r_w + KD_W'(1);
                end
            end
            S_DRAIN: begin
                if (!r_s1_v && !r_s2_v) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_v || o_res.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_h     <= '0;
            r_w     <= '0;
            r_kidx  <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
            for (int i = 0; i < KK; i++) begin
                r_coef[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_h     <= n_h;
            r_w     <= n_w;
            r_kidx  <= n_kidx;
            r_s1_v  <= n_s1_v;
            r_s2_v  <= r_s1_v;
            if (pop && i_cmd.coef_we) begin
                r_coef[i_cmd.coef_idx] <= i_cmd.coef_val;
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_cmd;
        end
        r_s1_coef <= r_coef[r_kidx];
        r_s1_skip <= skip;
        r_s2_prod <= r_s1_coef * pix_s;
        if (pop) begin
            r_acc <= '0;
        end else if (r_s2_v) begin
            r_acc <= r_acc + ACC_W'(r_s2_prod);
        end
        if (out_load) begin
            r_out_pix  <= res_pix;
            r_out_last <= r_cmd.last;
        end
    end

    // row store
    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.pix_we) begin
            r_mem[i_cmd.wr_slot][i_cmd.wr_col] <= i_cmd.pix;
        end
        r_rd <= r_mem[rd_slot][rd_col];
    end

    assign o_pop            = pop;
    assign o_res.valid      = r_out_v;
    assign o_res.out_pixel  = r_out_pix;
    assign o_res.frame_last = r_out_last;

endmodule

// File: rtl/padded_kernel_convolution.sv
// Top level of the padded kernel convolution block: configuration registers,
// front part, command queue and back part. Depends on pkc_pkg and the interfaces.
`timescale 1ns / 1ps

// Pixels enter in raster order and each output pixel is the kernel-weighted
// sum over its window, with edge-replicate or zero padding, shifted down by
// the coefficient fraction bits and clamped to 0..255. A coefficient load, a
// dropped request or a pixel that produces no output skips the tap pass.
// A transaction that produces an output occupies the back part through its
// tap, drain and finish states: the window is read one tap per
// cycle from a row store with one read and one write port, holding
// 3 * (MAX_KERNEL / 2) + 1 rows, and fed through one multiplier. A 4-entry
// command queue lets requests keep
// arriving while a result waits on the output register. After the last pixel
// of a frame, one flush transaction is needed per remaining output; the final
// output carries frame_last. No clearing pass is run after reset. Registers
// sit at byte addresses 0, 4, 8, 12, 16: width, height, kernel width, kernel
// height, pad mode (1 = zero padding); any register write restarts the frame.

module padded_kernel_convolution import pkc_pkg::*; #(
    parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT     = MAX_HEIGHT_DEF,
    parameter int MAX_KERNEL     = MAX_KERNEL_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pkc_req_if.sink               i_req,
    pkc_res_if.source             o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WD_W   = $clog2(MAX_WIDTH + 1);
    localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
    localparam int KD_W   = $clog2(MAX_KERNEL + 1);
    localparam int KK     = MAX_KERNEL * MAX_KERNEL;
    localparam int KI_W   = (KK > 1) ? $clog2(KK) : 1;
    localparam int NSLOT  = 2 * (MAX_KERNEL / 2) + MAX_KERNEL / 2 + 1;
    localparam int SLOT_W = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int RCV_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    typedef struct packed {
        logic [WD_W-1:0]  width;
        logic [HD_W-1:0]  height;
        logic [KD_W-1:0]  kw;
        logic [KD_W-1:0]  kh;
        logic             pad_zero;
        logic [RCV_W-1:0] lag;
    } t_geom;

    typedef struct packed {
        logic                     coef_we;
        logic [KI_W-1:0]          coef_idx;
        logic signed [COEF_W-1:0] coef_val;
        logic                     pix_we;
        logic [SLOT_W-1:0]        wr_slot;
        logic [COL_W-1:0]         wr_col;
        logic [PIX_W-1:0]         pix;
        logic                     emit;
        logic [ROW_W-1:0]         out_row;
        logic [COL_W-1:0]         out_col;
        logic [SLOT_W-1:0]        out_slot;
        logic                     last;
    } t_cmd;

    logic [DIM_CFG_W-1:0] r_width, r_height;
    logic [KER_CFG_W-1:0] r_kw, r_kh;
    logic                 r_pad;
    logic                 cfg_wr, cfg_hit;
    t_reg_idx             reg_idx;
    t_geom                geom;
    t_cmd                 push_cmd, head_cmd;
    logic                 push, pop, full, empty;
    logic [KD_W-1:0]      ph_e, pw_e;

    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb begin
        cfg_hit = 1'b0;
        prdata  = '0;
        unique case (reg_idx)
            REG_WIDTH:  begin cfg_hit = 1'b1; prdata = APB_DATA_W'(r_width);  end
            REG_HEIGHT: begin cfg_hit = 1'b1; prdata = APB_DATA_W'(r_height); end
            REG_KW:     begin cfg_hit = 1'b1; prdata = APB_DATA_W'(r_kw);     end
            REG_KH:     begin cfg_hit = 1'b1; prdata = APB_DATA_W'(r_kh);     end
            REG_PAD:    begin cfg_hit = 1'b1; prdata = APB_DATA_W'(r_pad);    end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_CFG_W'(1024);
            r_height <= DIM_CFG_W'(1024);
            r_kw     <= KER_CFG_W'(3);
            r_kh     <= KER_CFG_W'(3);
            r_pad    <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_WIDTH:  r_width  <= pwdata[DIM_CFG_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_CFG_W-1:0];
                REG_KW:     r_kw     <= pwdata[KER_CFG_W-1:0];
                REG_KH:     r_kh     <= pwdata[KER_CFG_W-1:0];
                REG_PAD:    r_pad    <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // zero acts as one, oversize values saturate at the built-in maximum
    always_comb begin
        if (r_width == '0) begin
            geom.width = WD_W'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            geom.width = WD_W'(MAX_WIDTH);
        end else begin
            geom.width = WD_W'(r_width);
        end
        if (r_height == '0) begin
            geom.height = HD_W'(1);
        end else if (32'(r_height) > MAX_HEIGHT) begin
            geom.height = HD_W'(MAX_HEIGHT);
        end else begin
            geom.height = HD_W'(r_height);
        end
        if (r_kw == '0) begin
            geom.kw = KD_W'(1);
        end else if (32'(r_kw) > MAX_KERNEL) begin
            geom.kw = KD_W'(MAX_KERNEL);
        end else begin
            geom.kw = KD_W'(r_kw);
        end
        if (r_kh == '0) begin
            geom.kh = KD_W'(1);
        end else if (32'(r_kh) > MAX_KERNEL) begin
            geom.kh = KD_W'(MAX_KERNEL);
        end else begin
            geom.kh = KD_W'(r_kh);
        end
        geom.pad_zero = r_pad;
        ph_e     = geom.kh >> 1;
        pw_e     = geom.kw >> 1;
        // outputs trail the input by this many pixels
        geom.lag = RCV_W'(ph_e) * RCV_W'(geom.width) + RCV_W'(pw_e);
    end

    pkc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_KERNEL (MAX_KERNEL),
        .t_geom     (t_geom),
        .t_cmd      (t_cmd)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_wr && cfg_hit),
        .i_geom    (geom),
        .i_req     (i_req),
        .o_push    (push),
        .o_cmd     (push_cmd),
        .i_full    (full)
    );

    pkc_fifo #(
        .DATA_W (($bits(t_cmd))),
        .DEPTH  (CMD_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_empty (empty)
    );

    pkc_back #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .MAX_KERNEL     (MAX_KERNEL),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .t_geom         (t_geom),
        .t_cmd          (t_cmd)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
